[rtl/core/assert_macros.svh]
// Assertion helpers for the RTL of the 4x4 matrix inverse.
// Each macro expands to one labeled concurrent assertion on a clock and an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// The condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

[rtl/core/mi4_pkg.sv]
// Shared types and tables for the 4x4 matrix inverse.
// No dependencies; used by mi4_lane and matrix_inverse_4x4.
`timescale 1ns / 1ps

package mi4_pkg;

    localparam int NUM_LANES = 4;
    localparam int NUM_TERMS = 6;

    typedef struct packed {
        logic go_minor;
        logic go_det;
        logic go_div;
    } lane_cmd_t;

    // Column picked in minor rows 2, 1 and 0 for one term of the 3x3 expansion.
    function automatic logic [5:0] perm_cols(input logic [2:0] term);
        logic [5:0] cols;
        case (term)
            3'd0: cols = {2'd2, 2'd1, 2'd0};
            3'd1: cols = {2'd1, 2'd2, 2'd0};
            3'd2: cols = {2'd2, 2'd0, 2'd1};
            3'd3: cols = {2'd0, 2'd2, 2'd1};
            3'd4: cols = {2'd1, 2'd0, 2'd2};
            3'd5: cols = {2'd0, 2'd1, 2'd2};
            default: cols = {2'd2, 2'd1, 2'd0};
        endcase
        return cols;
    endfunction

    // Odd permutations enter the 3x3 determinant with a minus sign.
    function automatic logic perm_neg(input logic [2:0] term);
        logic neg;
        case (term)
            3'd1, 3'd2, 3'd5: neg = 1'b1;
            default: neg = 1'b0;
        endcase
        return neg;
    endfunction

endpackage

[rtl/core/matrix_inverse_4x4.sv]
// Top level of the 4x4 fixed-point matrix inverse by the adjugate.
// Depends on mi4_pkg, mi4_lane and assert_macros.svh.
//
// Usage: the slave channel takes one matrix row per beat, four beats per
// matrix, elements in s_tdata from column 0 in the lowest bits. After the
// fourth beat the master channel gives the four rows of the inverse, one per
// beat; m_tlast marks the fourth row and m_tuser is set when the determinant
// is zero, in which case the rows are the identity.
// Four lanes work on the four columns at once; each runs one serial
// shift-and-add multiplier and one restoring divider. Each result row runs
// its minor, then the divide (skipped for a singular matrix), then the handoff
// to the output register; the first row adds the determinant after its minor.
// The input channel is ready only while rows are being collected, so the next
// matrix is taken only once the last row of the previous one has been handed
// to the output register.
// Reset is synchronous on aresetn and returns to row collection with no
// result pending. A stall on m_tready holds the output register and the
// lanes wait before the next row; the last row may wait there while the
// next matrix streams in.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module matrix_inverse_4x4
    import mi4_pkg::*;
#(
    parameter int ELEMENT_BITS  = 16,
    parameter int FRACTION_BITS = 8,
    localparam int TDW = ((4 * ELEMENT_BITS + 7) / 8) * 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [TDW-1:0] s_tdata,   // elem_col0, elem_col1, elem_col2, elem_col3
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [TDW-1:0] m_tdata,   // inv_col0, inv_col1, inv_col2, inv_col3
    output logic           m_tlast,   // row_is_last
    output logic [0:0]     m_tuser    // singular
);

    localparam int E  = ELEMENT_BITS;
    localparam int DW = 4 * E + 2;
    localparam logic signed [E-1:0] ONE_VAL = (FRACTION_BITS >= E - 1)
        ? E'((64'd1 << (E - 1)) - 64'd1) : E'(64'd1 << FRACTION_BITS);

    typedef enum logic [2:0] {T_IN, T_MINOR, T_DET, T_SUM, T_DIV, T_OUT} top_state_t;

    top_state_t            state_reg;
    logic [1:0]            beat_reg;
    logic [1:0]            row_reg;
    lane_cmd_t             cmd_reg;
    logic signed [E-1:0]   mat_reg [4][4];
    logic signed [DW-1:0]  det_reg;
    logic                  sing_reg;
    logic                  m_tvalid_reg;
    logic [TDW-1:0]        m_tdata_reg;
    logic                  m_tlast_reg;
    logic                  m_tuser_reg;

    logic [3:0]            lane_done;
    logic signed [DW-1:0]  lane_prod [4];
    logic signed [E-1:0]   lane_quot [4];
    logic signed [DW-1:0]  det_sum;
    logic [TDW-1:0]        out_data;
    logic                  out_free;

    // The store is rotated by one row after each result row, so the pivot
    // row always sits in row 0 and the minor rows keep their cyclic order.
    for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
        logic signed [E-1:0] r0 [3];
        logic signed [E-1:0] r1 [3];
        logic signed [E-1:0] r2 [3];
        for (genvar k = 0; k < 3; k++) begin : g_col
            localparam int MC = (k < c) ? k : k + 1;
            assign r0[k] = mat_reg[1][MC];
            assign r1[k] = mat_reg[2][MC];
            assign r2[k] = mat_reg[3][MC];
        end
        mi4_lane #(
            .ELEMENT_BITS  (ELEMENT_BITS),
            .FRACTION_BITS (FRACTION_BITS)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cmd     (cmd_reg),
            .cof_neg (row_reg[0] ^ 1'(c)),
            .m0      (r0),
            .m1      (r1),
            .m2      (r2),
            .pivot   (mat_reg[0][c]),
            .det     (det_reg),
            .done    (lane_done[c]),
            .prod    (lane_prod[c]),
            .quot    (lane_quot[c])
        );
    end

    always_comb begin
        det_sum  = lane_prod[0] + lane_prod[1] + lane_prod[2] + lane_prod[3];
        out_free = !m_tvalid_reg || m_tready;
        out_data = '0;
        for (int c = 0; c < NUM_LANES; c++) begin
            if (sing_reg) begin
                out_data[c*E +: E] = (row_reg == 2'(c)) ? ONE_VAL : '0;
            end else begin
                out_data[c*E +: E] = lane_quot[c];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= T_IN;
            beat_reg     <= 2'd0;
            row_reg      <= 2'd0;
            cmd_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            cmd_reg <= '0;
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                T_IN: begin
                    if (s_tvalid) begin
                        // Rows enter as columns, so the store holds the transpose.
                        for (int k = 0; k < 4; k++) begin
                            for (int j = 0; j < 3; j++) begin
                                mat_reg[k][j] <= mat_reg[k][j+1];
                            end
                            mat_reg[k][3] <= s_tdata[k*E +: E];
                        end
                        beat_reg <= beat_reg + 2'd1;
                        if (beat_reg == 2'd3) begin
                            row_reg          <= 2'd0;
                            cmd_reg.go_minor <= 1'b1;
                            state_reg        <= T_MINOR;
                        end
                    end
                end
                T_MINOR: begin
                    if (lane_done[0]) begin
                        if (row_reg == 2'd0) begin
                            cmd_reg.go_det <= 1'b1;
                            state_reg      <= T_DET;
                        end else if (sing_reg) begin
                            state_reg <= T_OUT;
                        end else begin
                            cmd_reg.go_div <= 1'b1;
                            state_reg      <= T_DIV;
                        end
                    end
                end
                T_DET: begin
                    if (lane_done[0]) begin
                        state_reg <= T_SUM;
                    end
                end
                T_SUM: begin
                    det_reg  <= det_sum;
                    sing_reg <= (det_sum == '0);
                    if (det_sum == '0) begin
                        state_reg <= T_OUT;
                    end else begin
                        cmd_reg.go_div <= 1'b1;
                        state_reg      <= T_DIV;
                    end
                end
                T_DIV: begin
                    if (lane_done[0]) begin
                        state_reg <= T_OUT;
                    end
                end
                T_OUT: begin
                    if (out_free) begin
                        m_tdata_reg  <= out_data;
                        m_tlast_reg  <= (row_reg == 2'd3);
                        m_tuser_reg  <= sing_reg;
                        m_tvalid_reg <= 1'b1;
                        if (row_reg == 2'd3) begin
                            state_reg <= T_IN;
                        end else begin
                            for (int k = 0; k < 4; k++) begin
                                mat_reg[k] <= mat_reg[2'(k + 1)];
                            end
                            row_reg          <= row_reg + 2'd1;
                            cmd_reg.go_minor <= 1'b1;
                            state_reg        <= T_MINOR;
                        end
                    end
                end
                default: state_reg <= T_IN;
            endcase
        end
    end

    assign s_tready   = (state_reg == T_IN);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tlast    = m_tlast_reg;
    assign m_tuser[0] = m_tuser_reg;

    `ASSERT_CLK(a_lanes_lockstep, aclk, aresetn, (lane_done == 4'b0000) || (lane_done == 4'b1111), "lanes finished out of step")
    `ASSERT_CLK(a_last_beat_starts, aclk, aresetn, (s_tvalid && s_tready && beat_reg == 2'd3) |=> cmd_reg.go_minor, "fourth row beat did not start the minors")
    `ASSERT_NEVER(a_no_div_singular, aclk, aresetn, sing_reg && cmd_reg.go_div, "divide started on a singular matrix")
    `ASSERT_NEVER(a_idle_while_ready, aclk, aresetn, s_tready && (lane_done != 4'b0000), "lane finished while collecting rows")

endmodule

[rtl/core/mi4_lane.sv]
// One lane of the inverse: 3x3 minor, its share of the determinant and one divide.
// Depends on mi4_pkg; instantiated four times by matrix_inverse_4x4.
`timescale 1ns / 1ps

module mi4_lane
    import mi4_pkg::*;
#(
    parameter int ELEMENT_BITS  = 16,
    parameter int FRACTION_BITS = 8,
    localparam int DW = 4 * ELEMENT_BITS + 2
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  lane_cmd_t                      cmd,
    input  logic                           cof_neg,
    input  logic signed [ELEMENT_BITS-1:0] m0 [3],
    input  logic signed [ELEMENT_BITS-1:0] m1 [3],
    input  logic signed [ELEMENT_BITS-1:0] m2 [3],
    input  logic signed [ELEMENT_BITS-1:0] pivot,
    input  logic signed [DW-1:0]           det,
    output logic                           done,
    output logic signed [DW-1:0]           prod,
    output logic signed [ELEMENT_BITS-1:0] quot
);

    localparam int E   = ELEMENT_BITS;
    localparam int CW  = 3 * E + 1;
    localparam int NW  = 3 * E + 2 * FRACTION_BITS;
    localparam int BW  = $clog2(E);
    localparam int NCW = $clog2(NW);
    localparam logic [BW-1:0]  BIT_TOP = BW'(E - 1);
    localparam logic [NCW-1:0] CNT_TOP = NCW'(NW - 1);
    localparam logic [E:0]     LIM_POS = (E + 1)'((64'd1 << (E - 1)) - 64'd1);
    localparam logic [E:0]     LIM_NEG = (E + 1)'(64'd1 << (E - 1));
    localparam logic [2:0]     LAST_TERM = 3'(NUM_TERMS - 1);

    typedef enum logic [1:0] {L_IDLE, L_MUL, L_ACC, L_DIV} lane_state_t;
    typedef enum logic [1:0] {MP_AB, MP_C, MP_PIVOT} mul_pass_t;

    lane_state_t           state_reg;
    mul_pass_t             pass_reg;
    logic signed [DW-1:0]  x_reg;
    logic [E-1:0]          y_reg;
    logic [BW-1:0]         bit_reg;
    logic signed [DW-1:0]  acc_reg;
    logic [2:0]            term_reg;
    logic signed [CW-1:0]  sum_reg;
    logic signed [CW-1:0]  cof_reg;
    logic [NW-1:0]         num_reg;
    logic [DW-2:0]         den_reg;
    logic [DW-2:0]         rem_reg;
    logic [E:0]            q_reg;
    logic                  ovf_reg;
    logic                  neg_reg;
    logic [NCW-1:0]        cnt_reg;
    logic                  done_reg;
    logic signed [DW-1:0]  prod_reg;
    logic signed [E-1:0]   quot_reg;

    logic signed [DW-1:0]  mul_add;
    logic signed [DW-1:0]  acc_step;
    logic signed [CW-1:0]  term_acc;
    logic [2:0]            term_sel;
    logic [5:0]            cols;
    logic signed [E-1:0]   a_sel;
    logic signed [E-1:0]   b_sel;
    logic signed [E-1:0]   c_sel;
    logic [CW-1:0]         cof_abs;
    logic [DW-1:0]         det_abs;
    logic [DW-1:0]         rem_sh;
    logic                  div_ge;
    logic [DW-1:0]         rem_sub;
    logic [E:0]            q_next;
    logic                  ovf_next;
    logic signed [E-1:0]   quot_sat;

    always_comb begin
        mul_add = y_reg[bit_reg] ? x_reg : '0;
        if (bit_reg == BIT_TOP) begin
            acc_step = y_reg[E-1] ? -x_reg : '0;
        end else begin
            acc_step = (acc_reg <<< 1) + mul_add;
        end
        term_acc = perm_neg(term_reg) ? sum_reg - CW'(acc_reg) : sum_reg + CW'(acc_reg);

        case (state_reg)
            L_IDLE:  term_sel = 3'd0;
            L_ACC:   term_sel = term_reg + 3'd1;
            default: term_sel = term_reg;
        endcase
        cols  = perm_cols(term_sel);
        a_sel = m0[cols[1:0]];
        b_sel = m1[cols[3:2]];
        c_sel = m2[cols[5:4]];

        cof_abs  = cof_reg[CW-1] ? CW'(-cof_reg) : CW'(cof_reg);
        det_abs  = det[DW-1] ? DW'(-det) : DW'(det);
        rem_sh   = {rem_reg, num_reg[NW-1]};
        div_ge   = rem_sh >= {1'b0, den_reg};
        rem_sub  = div_ge ? rem_sh - {1'b0, den_reg} : rem_sh;
        q_next   = {q_reg[E-1:0], div_ge};
        ovf_next = ovf_reg | q_reg[E];

        if (neg_reg) begin
            if (ovf_next || q_next > LIM_NEG) begin
                quot_sat = E'(LIM_NEG);
            end else begin
                quot_sat = -$signed(q_next[E-1:0]);
            end
        end else begin
            if (ovf_next || q_next > LIM_POS) begin
                quot_sat = E'(LIM_POS);
            end else begin
                quot_sat = $signed(q_next[E-1:0]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                L_IDLE: begin
                    if (cmd.go_minor) begin
                        sum_reg   <= '0;
                        term_reg  <= 3'd0;
                        x_reg     <= DW'(a_sel);
                        y_reg     <= b_sel;
                        bit_reg   <= BIT_TOP;
                        pass_reg  <= MP_AB;
                        state_reg <= L_MUL;
                    end else if (cmd.go_det) begin
                        x_reg     <= DW'(cof_reg);
                        y_reg     <= pivot;
                        bit_reg   <= BIT_TOP;
                        pass_reg  <= MP_PIVOT;
                        state_reg <= L_MUL;
                    end else if (cmd.go_div) begin
                        num_reg   <= NW'(cof_abs[3*E-1:0]) << (2 * FRACTION_BITS);
                        den_reg   <= det_abs[DW-2:0];
                        rem_reg   <= '0;
                        q_reg     <= '0;
                        ovf_reg   <= 1'b0;
                        neg_reg   <= cof_reg[CW-1] ^ det[DW-1];
                        cnt_reg   <= CNT_TOP;
                        state_reg <= L_DIV;
                    end
                end
                L_MUL: begin
                    // Shift-and-add over the bits of y, most significant first.
                    acc_reg <= acc_step;
                    bit_reg <= bit_reg - 1'b1;
                    if (bit_reg == '0) begin
                        case (pass_reg)
                            MP_AB: begin
                                x_reg    <= acc_step;
                                y_reg    <= c_sel;
                                bit_reg  <= BIT_TOP;
                                pass_reg <= MP_C;
                            end
                            MP_C: begin
                                state_reg <= L_ACC;
                            end
                            default: begin
                                prod_reg  <= acc_step;
                                done_reg  <= 1'b1;
                                state_reg <= L_IDLE;
                            end
                        endcase
                    end
                end
                L_ACC: begin
                    if (term_reg == LAST_TERM) begin
                        cof_reg   <= cof_neg ? -term_acc : term_acc;
                        done_reg  <= 1'b1;
                        state_reg <= L_IDLE;
                    end else begin
                        sum_reg   <= term_acc;
                        term_reg  <= term_reg + 3'd1;
                        x_reg     <= DW'(a_sel);
                        y_reg     <= b_sel;
                        bit_reg   <= BIT_TOP;
                        pass_reg  <= MP_AB;
                        state_reg <= L_MUL;
                    end
                end
                L_DIV: begin
                    // Restoring division, one quotient bit per cycle.
                    rem_reg <= rem_sub[DW-2:0];
                    num_reg <= num_reg << 1;
                    q_reg   <= q_next;
                    ovf_reg <= ovf_next;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        quot_reg  <= quot_sat;
                        done_reg  <= 1'b1;
                        state_reg <= L_IDLE;
                    end
                end
                default: state_reg <= L_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;
    assign quot = quot_reg;

endmodule

[test/matrix_inverse_4x4_checker.sv]
// Checker for the 4x4 matrix inverse: watches both stream channels, predicts
// the inverse rows from the accepted input rows, and compares every output beat.
`timescale 1ns / 1ps

module matrix_inverse_4x4_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic        m_tlast,
    input  logic [0:0]  m_tuser,
    input  logic        drain_done,
    output int          rows_pending,
    output int          fail_count
);

    typedef struct {
        logic signed [15:0] col[4];
        logic               is_last;
        logic               singular;
    } inv_row_t;

    logic signed [15:0] matrix[4][4];
    int                 row_idx;
    inv_row_t           expected_rows[$];
    logic               leftovers_reported;

    task automatic report(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    function automatic longint cofactor_of(input int r, input int c);
        longint m[3][3];
        longint d;
        int a, b;
        a = 0;
        for (int i = 0; i < 4; i++) begin
            if (i == r) continue;
            b = 0;
            for (int j = 0; j < 4; j++) begin
                if (j == c) continue;
                m[a][b] = matrix[i][j];
                b++;
            end
            a++;
        end
        d = m[0][0] * m[1][1] * m[2][2] - m[0][0] * m[1][2] * m[2][1]
          - m[0][1] * m[1][0] * m[2][2] + m[0][1] * m[1][2] * m[2][0]
          + m[0][2] * m[1][0] * m[2][1] - m[0][2] * m[1][1] * m[2][0];
        return ((r + c) % 2 == 1) ? -d : d;
    endfunction

    // Inverse = transposed cofactors / determinant, in Q8.8, truncated and saturated.
    task automatic predict_inverse();
        longint              cof[4][4];
        logic signed [95:0]  det, num, quo;
        inv_row_t            row;
        det = 0;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                cof[r][c] = cofactor_of(r, c);
        for (int c = 0; c < 4; c++) begin
            num = cof[0][c];
            det = det + num * matrix[0][c];
        end
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (det == 0) begin
                    row.col[c] = (r == c) ? 16'sd256 : 16'sd0;
                end else begin
                    num = cof[c][r];
                    num = num <<< 16;
                    quo = num / det;
                    if (quo > 96'sd32767)
                        row.col[c] = 16'sh7fff;
                    else if (quo < -96'sd32768)
                        row.col[c] = 16'sh8000;
                    else
                        row.col[c] = quo[15:0];
                end
            end
            row.is_last  = (r == 3);
            row.singular = (det == 0);
            expected_rows.push_back(row);
        end
    endtask

    initial begin
        fail_count = 0;
        rows_pending = 0;
        row_idx = 0;
        leftovers_reported = 0;
    end

    always @(posedge aclk) begin
        inv_row_t exp_row;
        if (!aresetn) begin
            row_idx = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                for (int c = 0; c < 4; c++)
                    matrix[row_idx][c] = s_tdata[16*c +: 16];
                if (row_idx == 3) begin
                    predict_inverse();
                    row_idx = 0;
                end else begin
                    row_idx++;
                end
            end
            if (m_tvalid && m_tready) begin
                if (expected_rows.size() == 0) begin
                    report($sformatf("unexpected output beat %h", m_tdata));
                end else begin
                    exp_row = expected_rows.pop_front();
                    for (int c = 0; c < 4; c++)
                        if (m_tdata[16*c +: 16] !== exp_row.col[c])
                            report($sformatf("inv_col%0d got %h expected %h",
                                c, m_tdata[16*c +: 16], exp_row.col[c]));
                    if (m_tlast !== exp_row.is_last)
                        report($sformatf("row_is_last got %b expected %b",
                            m_tlast, exp_row.is_last));
                    if (m_tuser[0] !== exp_row.singular)
                        report($sformatf("singular got %b expected %b",
                            m_tuser[0], exp_row.singular));
                end
            end
            if (drain_done && !leftovers_reported) begin
                leftovers_reported = 1;
                while (expected_rows.size() > 0) begin
                    exp_row = expected_rows.pop_front();
                    report("expected row never arrived");
                end
            end
            rows_pending = expected_rows.size();
        end
    end

endmodule

[test/matrix_inverse_4x4_tb.sv]
// Testbench top for matrix_inverse_4x4: drives matrices row by row with random
// gaps and output stalls; matrix_inverse_4x4_checker predicts and compares.
`timescale 1ns / 1ps

module matrix_inverse_4x4_tb;

    localparam int CYCLE_LIMIT = 600000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;
    logic        drain_done;
    int          rows_pending;
    int          fail_count;
    int          cycles;

    matrix_inverse_4x4 dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    matrix_inverse_4x4_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .drain_done(drain_done), .rows_pending(rows_pending), .fail_count(fail_count)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Mostly random gaps, with about a third of beats back to back.
    function automatic int draw_gap();
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
    endfunction

    task automatic send_row(input logic [15:0] c0, c1, c2, c3);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {c3, c2, c1, c0};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_matrix(input logic [15:0] m[4][4]);
        for (int r = 0; r < 4; r++)
            send_row(m[r][0], m[r][1], m[r][2], m[r][3]);
    endtask

    // Q8.8 matrix with a diagonal of +-2.0 and every element perturbed by a random value in [-0.5, 0.5).
    task automatic send_well_conditioned();
        logic [15:0] m[4][4];
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                m[r][c] = 16'($signed($urandom_range(0, 255)) - 128)
                        + ((r == c) ? 16'(($urandom_range(0, 1) ? 1 : -1) * 512) : 16'd0);
        send_matrix(m);
    endtask

    task automatic send_full_random();
        logic [15:0] m[4][4];
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                m[r][c] = 16'($urandom);
        send_matrix(m);
    endtask

    // A random matrix whose last row repeats another row, so it is singular.
    task automatic send_singular_random();
        logic [15:0] m[4][4];
        int src;
        src = $urandom_range(0, 2);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                m[r][c] = (r == 3) ? m[src][c] : 16'($signed($urandom_range(0, 2047)) - 1024);
        send_matrix(m);
    endtask

    task automatic send_diag(input logic [15:0] d0, d1, d2, d3);
        logic [15:0] m[4][4];
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                m[r][c] = 16'd0;
        m[0][0] = d0; m[1][1] = d1; m[2][2] = d2; m[3][3] = d3;
        send_matrix(m);
    endtask

    initial begin
        int gap;
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    initial begin
        logic [15:0] m[4][4];
        int kind;
        cycles     = 0;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        drain_done = 1'b0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Identity, an all-zero matrix, and diagonals that force saturation.
        send_diag(16'd256, 16'd256, 16'd256, 16'd256);
        send_diag(16'd0, 16'd0, 16'd0, 16'd0);
        send_diag(16'd1, 16'hffff, 16'h7fff, 16'h8000);
        send_diag(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        // Every element at the most positive value: singular.
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                m[r][c] = 16'h7fff;
        send_matrix(m);
        // A checkerboard of extremes with a nonzero determinant.
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                m[r][c] = (r == c) ? 16'h8000 : ((r + c) % 2 ? 16'h7fff : 16'h0001);
        send_matrix(m);

        for (int n = 0; n < 32; n++) begin
            kind = $urandom_range(0, 9);
            if (kind < 6)
                send_well_conditioned();
            else if (kind < 8)
                send_full_random();
            else
                send_singular_random();
        end
        s_tvalid <= 1'b0;

        while (rows_pending != 0) @(negedge aclk);
        repeat (400) @(negedge aclk);
        drain_done <= 1'b1;
        @(negedge aclk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
